// ===== sv/tnv_pkg.sv =====
// Shared types and constants for the tag nesting validator.
// No dependencies; imported by the top level.
package tnv_pkg;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_TEXT   = 3'd1,
        MODE_LT     = 3'd2,
        MODE_NAME   = 3'd3,
        MODE_PREFIX = 3'd4,
        MODE_CDATA  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;

    // Length of the CDATA opener after "<!", i.e. "[CDATA[".
    localparam logic [2:0] PREFIX_LEN = 3'd7;

    function automatic logic [7:0] cdata_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h5B;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h44;
            3'd3:    ch = 8'h41;
            3'd4:    ch = 8'h54;
            3'd5:    ch = 8'h41;
            3'd6:    ch = 8'h5B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/tnv_if.sv =====
// Valid/ready channel interfaces for the byte input and the status output.
// Depends on nothing but the port widths fixed by the block.
interface tnv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface tnv_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] nest_depth;

    modport source (output valid, output status, output nest_depth, input ready);
    modport sink   (input valid, input status, input nest_depth, output ready);
endinterface

// ===== sv/tnv_stack_ram.sv =====
// Tag name stack storage: one write port, one read port, registered read data.
// Standalone; instantiated by tag_nesting_validator_top.
module tnv_stack_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 45,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/tag_nesting_validator_top.sv =====
// Tag nesting validator: checks a byte stream is one well-nested tag pair.
// Depends on tnv_pkg, tnv_in_if / tnv_out_if and tnv_stack_ram.
//
//  channel | dir | payload                  | request moves
//  i_in    | in  | char_byte[8], last_char  | one character
//  o_out   | out | status[2], nest_depth[7] | one status per character
//
// One character per cycle, and each accepted character's result is registered.
// The top of stack is held in a register; the RAM is read only after a pop to
// refetch the new top, and the shortest closing tag is long enough for that
// refetch through the RAM read register into the top register. Synchronous
// active-low reset clears all control state; the stack RAM needs no clearing.
// The input stalls only when the output register is full and not being drained.
module tag_nesting_validator_top #(
    parameter int STACK_DEPTH = 64,
    parameter int NAME_MAX    = 9
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tnv_in_if.sink    i_in,
    tnv_out_if.source o_out
);
    import tnv_pkg::*;

    localparam int NW = 5 * NAME_MAX;
    localparam int LW = $clog2(NAME_MAX + 1);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [CW-1:0] r_count,    n_count;
    logic [NW-1:0] r_accum,    n_accum;
    logic [LW-1:0] r_len,      n_len;
    t_mode         r_mode,     n_mode;
    logic [2:0]    r_prefix,   n_prefix;
    logic [1:0]    r_brk,      n_brk;
    logic          r_closing,  n_closing;
    logic          r_failed,   n_failed;
    logic          r_outer,    n_outer;
    logic [NW-1:0] r_tos,      n_tos;
    logic          r_rd_pend,  n_rd_pend;
    logic          r_out_valid;
    t_status       r_out_status, n_status;
    logic [6:0]    r_out_depth,  n_depth;

    logic          w_acc;
    logic          w_pop;
    logic [7:0]    w_ch;
    logic          w_letter;
    logic [4:0]    w_code;
    logic          w_wr_en, w_rd_en;
    logic [AW-1:0] w_wr_addr, w_rd_addr;
    logic [NW-1:0] w_wr_data, w_rd_data;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_ch       = i_in.char_byte;
    assign w_letter   = (w_ch >= CH_A) && (w_ch <= CH_Z);
    assign w_code     = 5'(w_ch - 8'h40);

    tnv_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (NW),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_count   = r_count;
        n_accum   = r_accum;
        n_len     = r_len;
        n_mode    = r_mode;
        n_prefix  = r_prefix;
        n_brk     = r_brk;
        n_closing = r_closing;
        n_failed  = r_failed;
        n_outer   = r_outer;
        n_tos     = r_rd_pend ? w_rd_data : r_tos;
        n_rd_pend = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = r_accum;
        w_rd_en   = 1'b0;
        w_rd_addr = AW'(r_count - CW'(2));
        w_pop     = 1'b0;
        n_status  = ST_PENDING;
        n_depth   = 7'(r_count);

        if (w_acc) begin
            if (!r_failed) begin
                if (r_outer) begin
                    n_failed = 1'b1;
                end else begin
                    case (r_mode)
                        MODE_START: begin
                            if (w_ch == CH_LT) n_mode = MODE_LT;
                            else               n_failed = 1'b1;
                        end
                        MODE_TEXT: begin
                            if (w_ch == CH_LT) n_mode = MODE_LT;
                        end
                        MODE_LT: begin
                            if (w_ch == CH_SLASH) begin
                                if (r_count == '0) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_closing = 1'b1;
                                    n_accum   = '0;
                                    n_len     = '0;
                                    n_mode    = MODE_NAME;
                                end
                            end else if (w_ch == CH_BANG) begin
                                if (r_count == '0) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_prefix = '0;
                                    n_mode   = MODE_PREFIX;
                                end
                            end else if (w_letter) begin
                                n_closing = 1'b0;
                                n_accum   = NW'(w_code);
                                n_len     = LW'(1);
                                n_mode    = MODE_NAME;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        MODE_NAME: begin
                            if (w_letter) begin
                                if (r_len >= LW'(NAME_MAX)) begin
                                    n_failed = 1'b1;
                                end else begin
                                    n_accum = (r_accum << 5) | NW'(w_code);
                                    n_len   = r_len + LW'(1);
                                end
                            end else if (w_ch == CH_GT) begin
                                if (r_len == '0) begin
                                    n_failed = 1'b1;
                                end else if (!r_closing) begin
                                    if (r_count >= CW'(STACK_DEPTH)) begin
                                        n_failed = 1'b1;
                                    end else begin
                                        w_wr_en = 1'b1;
                                        n_tos   = r_accum;
                                        n_count = r_count + CW'(1);
                                        n_mode  = MODE_TEXT;
                                    end
                                end else if (r_tos != r_accum) begin
                                    n_failed = 1'b1;
                                end else begin
                                    // Refetch the entry that becomes the new top.
                                    w_pop     = 1'b1;
                                    n_count   = r_count - CW'(1);
                                    w_rd_en   = (r_count > CW'(1));
                                    n_rd_pend = w_rd_en;
                                    n_outer   = (r_count == CW'(1));
                                    n_mode    = MODE_TEXT;
                                end
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        MODE_PREFIX: begin
                            if (r_prefix < PREFIX_LEN && w_ch == cdata_char(r_prefix)) begin
                                n_prefix = r_prefix + 3'd1;
                                if (n_prefix == PREFIX_LEN) begin
                                    n_brk  = '0;
                                    n_mode = MODE_CDATA;
                                end
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        MODE_CDATA: begin
                            if (w_ch == CH_RBRACK) begin
                                if (r_brk < 2'd2) n_brk = r_brk + 2'd1;
                            end else if (w_ch == CH_GT && r_brk == 2'd2) begin
                                n_brk  = '0;
                                n_mode = MODE_TEXT;
                            end else begin
                                n_brk = '0;
                            end
                        end
                        default: begin
                            n_failed = 1'b1;
                        end
                    endcase
                end
            end

            if (i_in.last_char) begin
                n_status = (!n_failed && n_outer) ? ST_ACCEPTED : ST_REJECTED;
            end else begin
                n_status = n_failed ? ST_REJECTED : ST_PENDING;
            end
            n_depth = 7'(n_count);

            // The string is over: return to the reset state.
            if (i_in.last_char) begin
                n_count   = '0;
                n_accum   = '0;
                n_len     = '0;
                n_mode    = MODE_START;
                n_prefix  = '0;
                n_brk     = '0;
                n_closing = 1'b0;
                n_failed  = 1'b0;
                n_outer   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_accum     <= '0;
            r_len       <= '0;
            r_mode      <= MODE_START;
            r_prefix    <= '0;
            r_brk       <= '0;
            r_closing   <= 1'b0;
            r_failed    <= 1'b0;
            r_outer     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_accum     <= n_accum;
            r_len       <= n_len;
            r_mode      <= n_mode;
            r_prefix    <= n_prefix;
            r_brk       <= n_brk;
            r_closing   <= n_closing;
            r_failed    <= n_failed;
            r_outer     <= n_outer;
            r_rd_pend   <= n_rd_pend;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (w_acc) begin
            r_out_status <= n_status;
            r_out_depth  <= n_depth;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.nest_depth = r_out_depth;

`ifndef SYNTHESIS
    // A refetch of the top must land before the next pop compares against it.
    a_no_pop_during_refetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !w_pop)
        else $error("pop while top-of-stack refetch is pending");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.last_char) |=> (r_count == '0 && r_mode == MODE_START && !r_failed))
        else $error("state not cleared after last character");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_outer_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outer |-> (r_count == '0))
        else $error("outer tag closed with tags still open");

    a_accept_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_in.last_char) |=> (r_out_status != ST_ACCEPTED))
        else $error("accepted status on a character that is not last");
`endif

endmodule
